// ===== hdl/psa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the position sensor smoothing averager: widths, register codes,
// reset values, shared structures and the code-to-volts conversion. No dependencies.
package psa_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int RAW_W       = 16;
   localparam int VOLT_W      = FRAC_BITS + 3;
   localparam int MSUM_W      = VOLT_W + 3;
   localparam int SIX_W       = VOLT_W + 3;
   localparam int POS_W       = FRAC_BITS + 13;
   localparam int COEF_W      = 17;
   localparam int PROD_W      = COEF_W + POS_W;
   localparam int CNT_W       = 12;
   localparam int SUM_W       = POS_W + CNT_W + 1;
   localparam int DIVR_W      = 12;
   localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
   localparam int HIST_DEPTH  = 4;
   localparam int AVG_W       = 29;
   localparam int VOLT_OUT_W  = 19;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int GAIN_SHIFT  = 16;
   localparam int RAW_HALF    = 32768;
   localparam int CONV_SHIFT  = 15;
   localparam int RECIP_W     = 21;
   localparam int MEAN_SHIFT  = 23;

   localparam logic [COEF_W-1:0] GAIN_ONE     = COEF_W'(65536);
   localparam logic [SIX_W-1:0]  FULL_SCALE   = SIX_W'(30) << FRAC_BITS;
   localparam logic [DIVR_W-1:0] MEAN_TERMS   = DIVR_W'(5);
   localparam logic [RECIP_W-1:0] MEAN_RECIP  = RECIP_W'(1677722);
   localparam logic [AVG_W-1:0]  AVG_MAX      = AVG_W'(501350400);
   localparam logic [VOLT_OUT_W-1:0] VOLT_MAX = VOLT_OUT_W'(327680);

   localparam logic        RST_MODE   = 1'b1;
   localparam logic [7:0]  RST_HEIGHT = 8'd60;
   localparam logic [7:0]  RST_WIDTH  = 8'd25;
   localparam logic [15:0] RST_GAIN   = 16'd103;
   localparam logic [11:0] RST_WINDOW = 12'd1601;

   typedef enum logic [2:0] {
      CSR_MODE   = 3'd0,
      CSR_HEIGHT = 3'd1,
      CSR_WIDTH  = 3'd2,
      CSR_GAIN   = 3'd3,
      CSR_WINDOW = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic        mode_high_rate;
      logic [7:0]  scale_height;
      logic [7:0]  scale_width;
      logic [15:0] filter_gain;
      logic [11:0] window_count;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [AVG_W-1:0]      average_position;
      logic                  window_done;
      logic [VOLT_OUT_W-1:0] smoothed_volts;
   } result_type;

   function automatic logic [VOLT_W-1:0] to_volts(input logic [RAW_W-1:0] raw);
      logic [RAW_W-1:0]              r;
      logic [RAW_W+2:0]              r5;
      logic [RAW_W+2+FRAC_BITS:0]    t;
      r  = (raw > RAW_W'(RAW_HALF)) ? raw - RAW_W'(RAW_HALF) : raw;
      r5 = {r, 2'b00} + (RAW_W+3)'(r);
      t  = (RAW_W+3+FRAC_BITS)'(r5) << FRAC_BITS;
      return VOLT_W'(t >> CONV_SHIFT);
   endfunction

endpackage

// ===== hdl/psa_req_if.sv =====
`timescale 1ns / 1ps
// Request channel carrying one raw converter code per beat.
// Depends on psa_pkg.
interface psa_req_if import psa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] position_raw;

   modport source (output valid, output position_raw, input ready);
   modport sink   (input valid, input position_raw, output ready);
endinterface

// ===== hdl/psa_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel carrying one averaged position result per beat.
// Depends on psa_pkg.
interface psa_rsp_if import psa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [AVG_W-1:0]      average_position;
   logic                  window_done;
   logic [VOLT_OUT_W-1:0] smoothed_volts;

   modport source (output valid, output average_position, output window_done,
                   output smoothed_volts, input ready);
   modport sink   (input valid, input average_position, input window_done,
                   input smoothed_volts, output ready);
endinterface

// ===== hdl/psa_divider.sv =====
`timescale 1ns / 1ps
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on psa_pkg.
module psa_divider import psa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [DIVR_W-1:0]    rem_ff, rem_in;
   logic [DIVR_W-1:0]    dvs_ff, dvs_in;
   logic [DIVR_W:0]      trial;
   logic                 fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(SUM_W);
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIVR_W'(trial - {1'b0, dvs_ff}) : DIVR_W'(trial);
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== hdl/psa_csr.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers of the averager.
// Depends on psa_pkg.
module psa_csr import psa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   csr_index_type index;
   logic          write_en;

   assign index    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            CSR_MODE:   cfg_in.mode_high_rate = csr_pwdata[0];
            CSR_HEIGHT: cfg_in.scale_height   = csr_pwdata[7:0];
            CSR_WIDTH:  cfg_in.scale_width    = csr_pwdata[7:0];
            CSR_GAIN:   cfg_in.filter_gain    = csr_pwdata[15:0];
            CSR_WINDOW: cfg_in.window_count   = csr_pwdata[11:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_MODE:   csr_prdata = CSR_DATA_W'(cfg_ff.mode_high_rate);
         CSR_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.scale_height);
         CSR_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.scale_width);
         CSR_GAIN:   csr_prdata = CSR_DATA_W'(cfg_ff.filter_gain);
         CSR_WINDOW: csr_prdata = CSR_DATA_W'(cfg_ff.window_count);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_high_rate <= RST_MODE;
         cfg_ff.scale_height   <= RST_HEIGHT;
         cfg_ff.scale_width    <= RST_WIDTH;
         cfg_ff.filter_gain    <= RST_GAIN;
         cfg_ff.window_count   <= RST_WINDOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ===== hdl/psa_seq.sv =====
`timescale 1ns / 1ps
// Sequencer and datapath: in windowed mode a constant reciprocal product gives the mean,
// then one shared multiplier and the shared divider work through the scaling, two low-pass
// stages and the window average; direct mode does only the scaling. Depends on psa_pkg.
module psa_seq import psa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [RAW_W-1:0] in_raw,
   output logic             res_valid,
   output result_type       res_data,
   input  logic             res_ready
);

   typedef enum logic [11:0] {
      S_IDLE      = 12'h001,
      S_SUM       = 12'h002,
      S_SCALE     = 12'h004,
      S_POS_START = 12'h008,
      S_POS_WAIT  = 12'h010,
      S_LP_A      = 12'h020,
      S_LP_B      = 12'h040,
      S_LP_C      = 12'h080,
      S_ACC       = 12'h100,
      S_AVG_START = 12'h200,
      S_AVG_WAIT  = 12'h400,
      S_DONE      = 12'h800
   } state_type;

   state_type          state_ff, state_in;
   logic [VOLT_W-1:0]  volt_ff, volt_in;
   logic [VOLT_W-1:0]  mean_ff, mean_in;
   logic [VOLT_W-1:0]  hist_ff [HIST_DEPTH];
   logic [VOLT_W-1:0]  hist_in [HIST_DEPTH];
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   s1_ff, s1_in;
   logic [POS_W-1:0]   s2_ff, s2_in;
   logic               stage_ff, stage_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [POS_W-1:0]   avg_ff, avg_in;
   logic               done_ff, done_in;

   logic [MSUM_W-1:0]  mean_sum;
   logic [MSUM_W+RECIP_W-1:0] mean_prod;
   logic [VOLT_W-1:0]  mean_val;
   logic [SIX_W-1:0]   six;
   logic [SIX_W-1:0]   span;
   logic [COEF_W-1:0]  mul_a;
   logic [POS_W-1:0]   mul_b;
   logic [PROD_W-1:0]  mul_prod;
   logic [PROD_W:0]    lp_sum;
   logic [POS_W-1:0]   lp_out;
   logic [DIVR_W-1:0]  width_div;
   logic [CNT_W-1:0]   limit;
   logic [CNT_W-1:0]   cnt_next;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   psa_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign mean_sum  = MSUM_W'(volt_ff) + MSUM_W'(hist_ff[0]) + MSUM_W'(hist_ff[1])
                    + MSUM_W'(hist_ff[2]) + MSUM_W'(hist_ff[3]);
   assign mean_prod = (MSUM_W+RECIP_W)'(mean_sum) * (MSUM_W+RECIP_W)'(MEAN_RECIP);
   assign mean_val  = VOLT_W'(mean_prod >> MEAN_SHIFT);
   assign six       = {volt_ff, 2'b00} + SIX_W'({volt_ff, 1'b0});
   assign span      = (six > FULL_SCALE) ? '0 : FULL_SCALE - six;
   assign width_div = (cfg.scale_width == 8'd0) ? DIVR_W'(1) : DIVR_W'(cfg.scale_width);
   assign limit     = (cfg.window_count == '0) ? CNT_W'(1) : cfg.window_count;
   assign cnt_next  = cnt_ff + CNT_W'(1);
   assign mul_prod  = mul_a * mul_b;
   assign lp_sum    = (PROD_W+1)'(acc_ff) + (PROD_W+1)'(prod_ff);
   assign lp_out    = POS_W'(lp_sum >> GAIN_SHIFT);

   always_comb begin
      case (state_ff)
         S_SCALE: begin
            mul_a = COEF_W'(cfg.scale_height);
            mul_b = POS_W'(span);
         end
         S_LP_A: begin
            mul_a = COEF_W'(cfg.filter_gain);
            mul_b = stage_ff ? s1_ff : pos_ff;
         end
         S_LP_B: begin
            mul_a = GAIN_ONE - COEF_W'(cfg.filter_gain);
            mul_b = stage_ff ? s2_ff : s1_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = sum_ff;
      div_req.divisor  = cnt_ff;
      case (state_ff)
         S_POS_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = SUM_W'(prod_ff);
            div_req.divisor  = width_div;
         end
         S_AVG_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = sum_ff;
            div_req.divisor  = DIVR_W'(cnt_ff);
         end
         default: div_req.start = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      volt_in  = volt_ff;
      mean_in  = mean_ff;
      hist_in  = hist_ff;
      pos_in   = pos_ff;
      s1_in    = s1_ff;
      s2_in    = s2_ff;
      stage_in = stage_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      avg_in   = avg_ff;
      done_in  = done_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               volt_in  = to_volts(in_raw);
               mean_in  = '0;
               done_in  = 1'b0;
               state_in = cfg.mode_high_rate ? S_SUM : S_SCALE;
            end
         end
         S_SUM: begin
            volt_in    = mean_val;
            mean_in    = mean_val;
            hist_in[0] = mean_val;
            hist_in[1] = hist_ff[0];
            hist_in[2] = hist_ff[1];
            hist_in[3] = hist_ff[2];
            state_in   = S_SCALE;
         end
         S_SCALE: begin
            prod_in  = mul_prod;
            state_in = S_POS_START;
         end
         S_POS_START: state_in = S_POS_WAIT;
         S_POS_WAIT: begin
            if (div_rsp.done) begin
               if (cfg.mode_high_rate) begin
                  pos_in   = POS_W'(div_rsp.quotient);
                  stage_in = 1'b0;
                  state_in = S_LP_A;
               end else begin
                  avg_in   = POS_W'(div_rsp.quotient);
                  state_in = S_DONE;
               end
            end
         end
         S_LP_A: begin
            prod_in  = mul_prod;
            state_in = S_LP_B;
         end
         S_LP_B: begin
            acc_in   = prod_ff;
            prod_in  = mul_prod;
            state_in = S_LP_C;
         end
         S_LP_C: begin
            if (stage_ff) begin
               s2_in    = lp_out;
               state_in = S_ACC;
            end else begin
               s1_in    = lp_out;
               stage_in = 1'b1;
               state_in = S_LP_A;
            end
         end
         S_ACC: begin
            sum_in   = sum_ff + SUM_W'(s2_ff);
            cnt_in   = cnt_next;
            state_in = (cnt_next >= limit) ? S_AVG_START : S_DONE;
         end
         S_AVG_START: state_in = S_AVG_WAIT;
         S_AVG_WAIT: begin
            if (div_rsp.done) begin
               avg_in   = POS_W'(div_rsp.quotient);
               done_in  = 1'b1;
               sum_in   = '0;
               cnt_in   = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         s1_ff  <= '0;
         s2_ff  <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
         avg_ff <= '0;
      end else begin
         state_ff <= state_in;
         hist_ff  <= hist_in;
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         avg_ff   <= avg_in;
      end
      volt_ff  <= volt_in;
      mean_ff  <= mean_in;
      pos_ff   <= pos_in;
      stage_ff <= stage_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      done_ff  <= done_in;
   end

   assign in_ready                  = (state_ff == S_IDLE);
   assign res_valid                 = (state_ff == S_DONE);
   assign res_data.average_position = AVG_W'(avg_ff);
   assign res_data.window_done      = done_ff;
   assign res_data.smoothed_volts   = VOLT_OUT_W'(mean_ff);

endmodule

// ===== hdl/position_sensor_smoothing_averager_core.sv =====
`timescale 1ns / 1ps
// Top level of the position sensor smoothing averager: configuration block,
// sequenced datapath and response output register. Depends on psa_pkg and the channel interfaces.
//
//   Channel   Direction  Contents
//   req_ch    in         position_raw, one converter code per beat
//   rsp_ch    out        average_position, window_done, smoothed_volts per beat
//   csr_*     in/out     APB-style register port, five registers at 4*i
//
// In windowed mode a sample passes through the mean, the scaling pass through the shared
// 42-step radix-2 divider and the two low-pass stages; when a window closes, a second divider
// pass for the average follows. In direct mode a sample takes only the scaling pass. A new
// beat is taken only once the last result has left the datapath. The datapath stalls only
// while a finished result finds the output register still holding an unaccepted beat.
// Reset is synchronous and restores register defaults and clears the filter state.
// A result waits in the output register while the next sample is being worked on.
module position_sensor_smoothing_averager_core import psa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   psa_req_if.sink               req_ch,
   psa_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   logic       res_valid;
   logic       res_ready;
   result_type res_data;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;

   psa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   psa_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_raw    (req_ch.position_raw),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready)
   );

   assign res_ready = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
         out_data_in  = res_data;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.average_position = out_data_ff.average_position;
   assign rsp_ch.window_done      = out_data_ff.window_done;
   assign rsp_ch.smoothed_volts   = out_data_ff.smoothed_volts;

endmodule

// ===== hdl/psa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the averager top level, attached by bind.
// Depends on psa_pkg and position_sensor_smoothing_averager_core.
module psa_checker import psa_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [AVG_W-1:0]      rsp_average_position,
   input logic                  rsp_window_done,
   input logic [VOLT_OUT_W-1:0] rsp_smoothed_volts
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average_position)
         && $stable(rsp_window_done) && $stable(rsp_smoothed_volts))
      else $error("Stalled response beat changed.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request accepted while a sample was still being worked on.");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_average_position <= AVG_MAX && rsp_smoothed_volts <= VOLT_MAX)
      else $error("Response beat outside its value range.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response beat valid straight after reset.");

endmodule

bind position_sensor_smoothing_averager_core psa_checker u_psa_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_ch.valid),
   .req_ready            (req_ch.ready),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_average_position (rsp_ch.average_position),
   .rsp_window_done      (rsp_ch.window_done),
   .rsp_smoothed_volts   (rsp_ch.smoothed_volts)
);

// ===== verif/position_average_checker.sv =====
`timescale 1ns / 1ps
// Checker for the position sensor smoothing averager: follows register writes and
// request beats, predicts each result and compares it with the response beats.
// Depends on psa_pkg, psa_req_if and psa_rsp_if.
module position_average_checker import psa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   psa_req_if                    req_ch,
   psa_rsp_if                    rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    failures,
   output int                    pending
);

   cfg_type     settings;
   logic [63:0] volt_history [HIST_DEPTH];
   logic [63:0] stage_one;
   logic [63:0] stage_two;
   logic [63:0] window_sum;
   logic [11:0] sample_count;
   logic [63:0] last_average;
   result_type  pending_averages [$];
   int          mismatch_count = 0;

   function automatic logic [63:0] volts_of(input logic [RAW_W-1:0] raw);
      logic [63:0] r;
      r = 64'(raw);
      if (r > 64'(RAW_HALF))
         r = r - 64'(RAW_HALF);
      return ((r * 64'(MEAN_TERMS)) << FRAC_BITS) >> CONV_SHIFT;
   endfunction

   function automatic logic [63:0] position_of(input logic [63:0] volts);
      logic [63:0] full;
      logic [63:0] six;
      logic [63:0] span;
      logic [63:0] divisor;
      full    = 64'(30) << FRAC_BITS;
      six     = 64'(6) * volts;
      span    = (six > full) ? 64'(0) : full - six;
      divisor = (settings.scale_width == 8'd0) ? 64'(1) : 64'(settings.scale_width);
      return (span * 64'(settings.scale_height)) / divisor;
   endfunction

   function automatic logic [63:0] smooth(input logic [63:0] x, input logic [63:0] prev);
      logic [63:0] a;
      a = 64'(settings.filter_gain);
      return (a * x + (64'(GAIN_ONE) - a) * prev) >> GAIN_SHIFT;
   endfunction

   function automatic result_type next_average_result(input logic [RAW_W-1:0] raw);
      logic [63:0] volts;
      logic [63:0] mean;
      logic [63:0] limit;
      result_type  r;
      volts = volts_of(raw);
      mean  = 64'(0);
      r.window_done = 1'b0;
      if (settings.mode_high_rate) begin
         limit = (settings.window_count == 12'd0) ? 64'(1) : 64'(settings.window_count);
         mean  = (volts + volt_history[0] + volt_history[1] + volt_history[2] +
                  volt_history[3]) / 64'(MEAN_TERMS);
         volt_history[3] = volt_history[2];
         volt_history[2] = volt_history[1];
         volt_history[1] = volt_history[0];
         volt_history[0] = mean;
         stage_one    = smooth(position_of(mean), stage_one);
         stage_two    = smooth(stage_one, stage_two);
         window_sum   = window_sum + stage_two;
         sample_count = sample_count + 12'd1;
         if (64'(sample_count) >= limit) begin
            last_average  = (sample_count != 12'd0) ? window_sum / 64'(sample_count) : 64'(0);
            r.window_done = 1'b1;
            sample_count  = 12'd0;
            window_sum    = 64'(0);
         end
      end else begin
         last_average = position_of(volts);
      end
      r.average_position = last_average[AVG_W-1:0];
      r.smoothed_volts   = mean[VOLT_OUT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         settings = '{RST_MODE, RST_HEIGHT, RST_WIDTH, RST_GAIN, RST_WINDOW};
         for (int i = 0; i < HIST_DEPTH; i++)
            volt_history[i] = 64'(0);
         stage_one    = 64'(0);
         stage_two    = 64'(0);
         window_sum   = 64'(0);
         sample_count = 12'd0;
         last_average = 64'(0);
         pending_averages.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[4:2]))
               CSR_MODE:   settings.mode_high_rate = csr_pwdata[0];
               CSR_HEIGHT: settings.scale_height   = csr_pwdata[7:0];
               CSR_WIDTH:  settings.scale_width    = csr_pwdata[7:0];
               CSR_GAIN:   settings.filter_gain    = csr_pwdata[15:0];
               CSR_WINDOW: settings.window_count   = csr_pwdata[11:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_averages.size() == 0) begin
               $error("result beat arrived with no expectation waiting");
               mismatch_count++;
            end else begin
               want = pending_averages.pop_front();
               if (rsp_ch.average_position !== want.average_position) begin
                  $error("average_position mismatch: expected %0d, actual %0d",
                         want.average_position, rsp_ch.average_position);
                  mismatch_count++;
               end
               if (rsp_ch.window_done !== want.window_done) begin
                  $error("window_done mismatch: expected %0d, actual %0d",
                         want.window_done, rsp_ch.window_done);
                  mismatch_count++;
               end
               if (rsp_ch.smoothed_volts !== want.smoothed_volts) begin
                  $error("smoothed_volts mismatch: expected %0d, actual %0d",
                         want.smoothed_volts, rsp_ch.smoothed_volts);
                  mismatch_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            pending_averages.push_back(next_average_result(req_ch.position_raw));
      end
      failures <= mismatch_count;
      pending  <= pending_averages.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the averager testbench: clock, reset, register programming, sample stimulus
// with idle and stall phases, and the verdict. Depends on psa_pkg, the channel
// interfaces, the averager core and position_average_checker.
module testbench;
   import psa_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 200;
   localparam int PHASES        = 11;
   localparam int PHASE_BEATS   = 55;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    failures;
   int                    pending;
   int                    cycle_count = 0;
   int                    send_idle_pct = 0;
   int                    stall_pct = 0;

   psa_req_if req_ch ();
   psa_rsp_if rsp_ch ();

   position_sensor_smoothing_averager_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   position_average_checker averages (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .failures    (failures),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic write_register(input csr_index_type index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(index) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_averager(input logic mode, input logic [7:0] height,
                                   input logic [7:0] width, input logic [15:0] gain,
                                   input logic [11:0] window);
      write_register(CSR_MODE, 32'(mode));
      write_register(CSR_HEIGHT, 32'(height));
      write_register(CSR_WIDTH, 32'(width));
      write_register(CSR_GAIN, 32'(gain));
      write_register(CSR_WINDOW, 32'(window));
   endtask

   task automatic program_random(input logic mode);
      logic [11:0] window;
      case ($urandom_range(0, 5))
         0:       window = 12'd0;
         1:       window = 12'd4095;
         2:       window = 12'($urandom_range(0, 4095));
         default: window = 12'($urandom_range(1, 12));
      endcase
      program_averager(mode, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       16'($urandom), window);
   endtask

   task automatic send_raw(input logic [RAW_W-1:0] raw);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.position_raw <= raw;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [RAW_W-1:0] pick_raw();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0:       return 16'd0;
               1:       return 16'hFFFF;
               2:       return 16'(RAW_HALF);
               default: return 16'(RAW_HALF + 1);
            endcase
         end
         1:       return 16'(RAW_HALF + $urandom_range(0, 8) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.position_raw <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: converter code extremes and the wrap at half scale.
      send_raw(16'd0);
      send_raw(16'hFFFF);
      send_raw(16'(RAW_HALF));
      send_raw(16'(RAW_HALF + 1));
      send_raw(16'(RAW_HALF - 1));
      send_raw(16'd1);
      drain_results();
      program_averager(1'b1, 8'd255, 8'd1, 16'hFFFF, 12'd2);
      send_raw(16'hFFFF);
      send_raw(16'd0);
      send_raw(16'(RAW_HALF));
      send_raw(16'hFFFF);
      drain_results();
      // Zero divisor, frozen filter and a zero window length.
      program_averager(1'b1, 8'd1, 8'd0, 16'd0, 12'd0);
      send_raw(16'd12345);
      send_raw(16'd40000);
      send_raw(16'd3);
      drain_results();
      program_averager(1'b0, 8'd255, 8'd1, 16'd1, 12'd3);
      send_raw(16'd0);
      send_raw(16'(RAW_HALF));
      send_raw(16'hFFFF);
      send_raw(16'(RAW_HALF + 1));

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase)
            0:       program_averager(1'b1, 8'd255, 8'd1, 16'hFFFF, 12'd4095);
            1:       program_averager(1'b1, 8'd1, 8'd255, 16'd1, 12'd1);
            2:       program_random(1'b0);
            default: program_random($urandom_range(0, 3) != 0);
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 84; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (phase == 5 && n == PHASE_BEATS / 2)
               drain_results();
            send_raw(pick_raw());
         end
      end
      drain_results();

      if (failures == 0 && pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
